FILE: sv/spk128_pkg.sv
// Shared constants and types for the Speck128 block cipher.
// Used by the round unit, the key word cell and the top level.
package spk128_pkg;

  // Widths of the cipher words and of the configuration port.
  localparam int WORD_W    = 64;
  localparam int KEY_WORDS = 4;
  localparam int CFG_IDX_W = 3;

  // Size of the round key store.
  localparam int MAX_ROUNDS = 64;
  localparam int RK_AW      = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);

  // Cipher constants.
  localparam int ROT_X               = 8;
  localparam int ROT_Y               = 3;
  localparam int DEFAULT_ROUNDS_BASE = 30;
  localparam int MIN_KEY_BYTES       = 9;
  localparam int MAX_KEY_BYTES       = 32;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD0   = 3'd0,
    REG_KEY_WORD1   = 3'd1,
    REG_KEY_WORD2   = 3'd2,
    REG_KEY_WORD3   = 3'd3,
    REG_KEY_LENGTH  = 3'd4,
    REG_ROUND_COUNT = 3'd5
  } cfg_reg_t;

  // The two halves of a block, or of the key schedule state.
  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } word_pair_t;

  // Control shared by all cells of the key word chain.
  typedef struct packed {
    logic load;
    logic shift;
  } kcell_ctl_t;

endpackage

FILE: sv/spk128_round.sv
// One Speck128 round, forward or inverse, as combinational logic.
// Depends on spk128_pkg for the word width, rotation amounts and word_pair_t.
module spk128_round import spk128_pkg::*; (
  input  logic              dec,
  input  word_pair_t        din,
  input  logic [WORD_W-1:0] round_key,
  output word_pair_t        dout
);

  logic [WORD_W-1:0] x_ror;
  logic [WORD_W-1:0] y_rol;
  logic [WORD_W-1:0] enc_x;
  logic [WORD_W-1:0] dec_y;
  logic [WORD_W-1:0] dec_diff;

  always_comb begin
    x_ror    = {din.x[ROT_X-1:0], din.x[WORD_W-1:ROT_X]};
    y_rol    = {din.y[WORD_W-ROT_Y-1:0], din.y[WORD_W-1:WORD_W-ROT_Y]};
    enc_x    = (x_ror + din.y) ^ round_key;
    dec_y    = din.y ^ din.x;
    dec_y    = {dec_y[ROT_Y-1:0], dec_y[WORD_W-1:ROT_Y]};
    dec_diff = (din.x ^ round_key) - dec_y;
    if (dec) begin
      dout.y = dec_y;
      dout.x = {dec_diff[WORD_W-ROT_X-1:0], dec_diff[WORD_W-1:WORD_W-ROT_X]};
    end else begin
      dout.x = enc_x;
      dout.y = y_rol ^ enc_x;
    end
  end

endmodule

FILE: sv/spk128_kcell.sv
// One cell of the key schedule word chain: holds one key word and passes it
// toward the head of the chain. Depends on spk128_pkg for WORD_W and kcell_ctl_t.
module spk128_kcell import spk128_pkg::*; (
  input  logic              clk,
  input  kcell_ctl_t        ctl,
  input  logic              tail,
  input  logic [WORD_W-1:0] load_word,
  input  logic [WORD_W-1:0] neighbor,
  input  logic [WORD_W-1:0] feedback,
  output logic [WORD_W-1:0] word
);

  // The tail cell takes the freshly updated word; the others take the word
  // of the cell behind them, so the chain rotates through the used words.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= load_word;
    end else if (ctl.shift) begin
      word <= tail ? feedback : neighbor;
    end
  end

endmodule

FILE: sv/speck128_block_cipher.sv
// Speck128 block cipher top level: configuration, key store, round sequencer.
// Depends on spk128_pkg, spk128_round and spk128_kcell.
//
// Usage. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) writes the key words 0 to 3, the key length in bytes and the
// round count; it is always ready and should only be used while the block
// is idle. Any write to a listed register marks the round key store stale.
// A block arrives as one transaction on the s_ channel (tuser selects
// encrypt or decrypt) and leaves as one transaction on the m_ channel.
//
// Timing. With R effective rounds (default 30 plus the key word count),
// the block runs one round per cycle through a single shared round unit
// reading one round key per cycle from the key store; a new block is only
// accepted once the previous one has left the sequencer, as s_tready is
// high only while idle. The first block after reset or after a register
// write first expands the keys, one schedule round per cycle while the key
// words rotate through a chain of cells.
//
// Reset clears the registers to their defaults and marks the keys stale.
// A result waits in the output register while the receiver stalls; the next
// block is still accepted and computed, and it parks until the output frees.
module speck128_block_cipher import spk128_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // Input blocks.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*WORD_W-1:0]  s_tdata,   // block_low [63:0], block_high [127:64]
  input  logic                 s_tuser,   // mode: 0 encrypt, 1 decrypt
  // Result blocks.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [2*WORD_W-1:0]  m_tdata    // result_low [63:0], result_high [127:64]
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_CRYPT  = 5'b01000,
    ST_DRAIN  = 5'b10000
  } state_t;

  localparam int CELLS = KEY_WORDS - 1;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [WORD_W-1:0] key_word [KEY_WORDS];
  logic [5:0]        key_length;
  logic [6:0]        round_count;
  logic              keys_ready;

  // Derived key geometry.
  logic [5:0]       eff_len;
  logic [2:0]       key_words_used;
  logic [1:0]       chain_len;
  logic [CNT_W-1:0] rounds;
  logic [KEY_WORDS*WORD_W-1:0] key_masked;

  // Datapath.
  logic              mode;
  word_pair_t        blk;
  logic [WORD_W-1:0] key_lead;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] cell_word [CELLS];
  kcell_ctl_t        cell_ctl;
  word_pair_t        rnd_in;
  word_pair_t        rnd_out;
  logic [WORD_W-1:0] rnd_key;
  logic              rnd_dec;

  // Round key store.
  logic [WORD_W-1:0] rk_mem [MAX_ROUNDS];
  logic [WORD_W-1:0] rk_q;
  logic              rk_we;
  logic [RK_AW-1:0]  rk_waddr;
  logic [WORD_W-1:0] rk_wdata;
  logic [RK_AW-1:0]  rk_raddr;

  // Output register.
  logic              out_valid;
  word_pair_t        out_pair;

  logic in_fire;
  logic out_free;
  logic out_load;
  logic last_cnt;

  function automatic logic [CNT_W-1:0] calc_rounds(input logic [6:0] rc,
                                                   input logic [2:0] words);
    int r;
    r = int'(rc);
    if (r == 0) begin
      r = DEFAULT_ROUNDS_BASE + int'(words);
    end
    if (r > MAX_ROUNDS) begin
      r = MAX_ROUNDS;
    end
    return CNT_W'(r);
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {out_pair.x, out_pair.y};
  assign out_free  = !out_valid || m_tready;
  assign last_cnt  = (cnt == rounds - CNT_W'(1));
  // A finished block moves into the output register once it is free.
  assign out_load  = out_free && ((state == ST_CRYPT && last_cnt) || state == ST_DRAIN);

  // Key length saturation, word count and byte masking.
  always_comb begin
    eff_len = key_length;
    if (eff_len < 6'(MIN_KEY_BYTES)) begin
      eff_len = 6'(MIN_KEY_BYTES);
    end
    if (eff_len > 6'(MAX_KEY_BYTES)) begin
      eff_len = 6'(MAX_KEY_BYTES);
    end
    key_words_used = 3'((7'(eff_len) + 7'd7) >> 3);
    chain_len      = 2'(key_words_used - 3'd1);
    rounds         = calc_rounds(round_count, key_words_used);
    for (int b = 0; b < KEY_WORDS * 8; b++) begin
      key_masked[8*b +: 8] = (6'(b) < eff_len) ? key_word[b / 8][8*(b % 8) +: 8] : 8'd0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
      key_length  <= 6'd16;
      round_count <= 7'd0;
      keys_ready  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KEY_WORD0:   key_word[0] <= cfg_data;
          REG_KEY_WORD1:   key_word[1] <= cfg_data;
          REG_KEY_WORD2:   key_word[2] <= cfg_data;
          REG_KEY_WORD3:   key_word[3] <= cfg_data;
          REG_KEY_LENGTH:  key_length  <= cfg_data[5:0];
          REG_ROUND_COUNT: round_count <= cfg_data[6:0];
          default: ;
        endcase
        if (cfg_index <= REG_ROUND_COUNT) begin
          keys_ready <= 1'b0;
        end
      end else if (state == ST_EXPAND && last_cnt) begin
        keys_ready <= 1'b1;
      end
    end
  end

  // The round unit serves both the key schedule and the block rounds.
  always_comb begin
    if (state == ST_EXPAND) begin
      rnd_in.x = cell_word[0];
      rnd_in.y = key_lead;
      rnd_key  = WORD_W'(cnt);
      rnd_dec  = 1'b0;
    end else begin
      rnd_in   = blk;
      rnd_key  = rk_q;
      rnd_dec  = mode;
    end
  end

  spk128_round u_round (
    .dec       (rnd_dec),
    .din       (rnd_in),
    .round_key (rnd_key),
    .dout      (rnd_out)
  );

  // Key word chain; cell j holds schedule word j + 1.
  assign cell_ctl.load  = in_fire && !keys_ready;
  assign cell_ctl.shift = (state == ST_EXPAND) && !last_cnt;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic [WORD_W-1:0] nb;
    if (j + 1 < CELLS) begin : g_mid
      assign nb = cell_word[j + 1];
    end else begin : g_end
      assign nb = '0;
    end
    spk128_kcell u_kcell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .tail      (chain_len == 2'(j + 1)),
      .load_word (key_masked[(j + 1) * WORD_W +: WORD_W]),
      .neighbor  (nb),
      .feedback  (rnd_out.x),
      .word      (cell_word[j])
    );
  end

  // Key store write and read addresses.
  always_comb begin
    rk_we    = 1'b0;
    rk_waddr = '0;
    rk_wdata = key_masked[WORD_W-1:0];
    if (in_fire && !keys_ready) begin
      rk_we = 1'b1;
    end else if (state == ST_EXPAND && !last_cnt) begin
      rk_we    = 1'b1;
      rk_waddr = RK_AW'(cnt + CNT_W'(1));
      rk_wdata = rnd_out.y;
    end

    rk_raddr = '0;
    if (state == ST_IDLE) begin
      rk_raddr = s_tuser ? RK_AW'(rounds - CNT_W'(1)) : '0;
    end else if (state == ST_FETCH) begin
      rk_raddr = mode ? RK_AW'(rounds - CNT_W'(1)) : '0;
    end else if (state == ST_CRYPT) begin
      rk_raddr = mode ? RK_AW'(rounds - cnt - CNT_W'(2)) : RK_AW'(cnt + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_waddr] <= rk_wdata;
    end
    rk_q <= rk_mem[rk_raddr];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = keys_ready ? ST_CRYPT : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (last_cnt) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_CRYPT;
      ST_CRYPT: begin
        if (last_cnt) begin
          state_next = out_free ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result may replace the one taken in the same cycle.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
        end
        ST_EXPAND: begin
          cnt <= last_cnt ? '0 : cnt + CNT_W'(1);
        end
        ST_FETCH: begin
          cnt <= '0;
        end
        ST_CRYPT: begin
          if (!last_cnt) begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode  <= s_tuser;
      blk.x <= s_tdata[2*WORD_W-1:WORD_W];
      blk.y <= s_tdata[WORD_W-1:0];
      if (!keys_ready) begin
        key_lead <= key_masked[WORD_W-1:0];
      end
    end
    if (state == ST_EXPAND && !last_cnt) begin
      key_lead <= rnd_out.y;
    end
    if (state == ST_CRYPT) begin
      blk <= rnd_out;
      if (last_cnt && out_free) begin
        out_pair <= rnd_out;
      end
    end
    if (state == ST_DRAIN && out_free) begin
      out_pair <= blk;
    end
  end

  // Checks on the sequencer and the key store.
  a_crypt_keys_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRYPT) |-> keys_ready)
    else $error("block rounds running on a stale key store");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRYPT || state == ST_EXPAND) |-> (cnt < rounds))
    else $error("round counter beyond the round count");

  a_store_write_when: assert property (@(posedge clk) disable iff (rst)
    rk_we |-> (state == ST_EXPAND || (in_fire && !keys_ready)))
    else $error("key store written outside key expansion");

  a_drain_holds_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> m_tvalid)
    else $error("parked result while the output register is empty");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for speck128_block_cipher: random and directed blocks
// under many key settings, checked against an in-bench Speck128 predictor.
// Depends on spk128_pkg and the cipher RTL.

module testbench;
  import spk128_pkg::*;

  // Meaning of the tuser bit on the input stream.
  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } cipher_mode_t;

  // Register indexes that the block does not decode; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [WORD_W-1:0]    ALL_ONES     = '1;
  localparam int                   DIRECTED_N   = 24;
  localparam int                   RANDOM_N     = 576;

  typedef struct {
    cipher_mode_t      mode;
    logic [WORD_W-1:0] block_low;
    logic [WORD_W-1:0] block_high;
  } block_req_t;

  typedef struct {
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
  } block_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [2*WORD_W-1:0]  s_tdata = '0;   // block_low [63:0], block_high [127:64]
  logic                 s_tuser = 1'b0; // mode: 0 encrypt, 1 decrypt
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [2*WORD_W-1:0]  m_tdata;        // result_low [63:0], result_high [127:64]

  speck128_block_cipher u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Blocks waiting to be sent, and results owed by the block in order.
  block_req_t pending_blocks[$];
  block_res_t owed_results[$];

  int n_fail    = 0;
  int n_queued  = 0;
  int n_enc     = 0;
  int n_dec     = 0;
  int n_results = 0;
  int n_writes  = 0;
  int n_phases  = 0;

  // ------------------------------------------------------------------
  // Speck128 predictor. It keeps its own copy of the key registers and
  // rebuilds the round key schedule lazily, the first time a block needs
  // it after reset or after any decoded register write.
  // ------------------------------------------------------------------
  logic [WORD_W-1:0] key_reg [KEY_WORDS];
  logic [5:0]        keylen_reg;
  logic [6:0]        rounds_reg;
  logic [WORD_W-1:0] sched [MAX_ROUNDS];
  bit                sched_fresh;

  // Key length is saturated into the 9..32 byte window.
  function automatic int key_bytes_eff();
    int n;
    n = keylen_reg;
    if (n < MIN_KEY_BYTES) n = MIN_KEY_BYTES;
    else if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
    return n;
  endfunction

  // Zero selects the default round count; anything past the store is clipped.
  function automatic int rounds_eff();
    int r;
    r = rounds_reg;
    if (r == 0) r = DEFAULT_ROUNDS_BASE + (key_bytes_eff() + 7) / 8;
    if (r > MAX_ROUNDS) r = MAX_ROUNDS;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // The schedule runs the cipher round on the key words, the round index
  // acting as the key. Bytes at or past the key length are masked to zero.
  function automatic void build_schedule();
    logic [WORD_W-1:0] kw [KEY_WORDS];
    int len, words, a, first;
    len   = key_bytes_eff();
    words = (len + 7) / 8;
    for (int i = 0; i < KEY_WORDS; i++) begin
      first = i * 8;
      if (len >= first + 8) kw[i] = key_reg[i];
      else if (len <= first) kw[i] = '0;
      else kw[i] = key_reg[i] & ((64'd1 << ((len - first) * 8)) - 64'd1);
    end
    sched[0] = kw[0];
    for (int i = 0; i + 1 < rounds_eff(); i++) begin
      a          = i % (words - 1) + 1;
      kw[a]      = (ror(kw[a], ROT_X) + kw[0]) ^ WORD_W'(i);
      kw[0]      = rol(kw[0], ROT_Y) ^ kw[a];
      sched[i+1] = kw[0];
    end
    sched_fresh = 1'b1;
  endfunction

  function automatic block_res_t predict_block(input block_req_t req);
    word_pair_t w;
    block_res_t res;
    int n;
    if (!sched_fresh) build_schedule();
    n   = rounds_eff();
    w.x = req.block_high;
    w.y = req.block_low;
    if (req.mode == MODE_ENCRYPT) begin
      for (int i = 0; i < n; i++) begin
        w.x = (ror(w.x, ROT_X) + w.y) ^ sched[i];
        w.y = rol(w.y, ROT_Y) ^ w.x;
      end
    end else begin
      for (int i = n - 1; i >= 0; i--) begin
        w.y = ror(w.y ^ w.x, ROT_Y);
        w.x = rol((w.x ^ sched[i]) - w.y, ROT_X);
      end
    end
    res.result_low  = w.y;
    res.result_high = w.x;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Idle pattern shared by both stream sides: mostly short gaps, now and
  // then a long one. Each side also drops into stretches with no gaps.
  // ------------------------------------------------------------------
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Data words lean on the corner values now and then.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ALL_ONES;
      2: return 64'd1 << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Input driver. The prediction is made at the edge where the input
  // transaction completes, so it always sees the settings in force.
  // ------------------------------------------------------------------
  block_req_t on_bus;
  int         tx_wait   = 0;
  bit         tx_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        owed_results.push_back(predict_block(on_bus));
        if (on_bus.mode == MODE_ENCRYPT) n_enc++;
        else n_dec++;
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        tx_wait = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end
      if (s_tvalid && !s_tready) begin
        // The offered block stays on the bus until it is taken.
      end else if (tx_wait > 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        on_bus = pending_blocks.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {on_bus.block_high, on_bus.block_low};
        s_tuser  <= on_bus.mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Output monitor with random back-pressure. Every result transaction
  // is matched against the oldest owed result, field by field.
  // ------------------------------------------------------------------
  int rx_wait   = 0;
  bit rx_steady = 1'b0;

  always @(posedge clk) begin : collect
    block_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (owed_results.size() == 0) begin
          $error("result transaction with no block outstanding: %h", m_tdata);
          n_fail++;
        end else begin
          want = owed_results.pop_front();
          if (m_tdata[WORD_W-1:0] !== want.result_low) begin
            $error("result_low: expected %h, got %h", want.result_low, m_tdata[WORD_W-1:0]);
            n_fail++;
          end
          if (m_tdata[2*WORD_W-1:WORD_W] !== want.result_high) begin
            $error("result_high: expected %h, got %h", want.result_high,
                   m_tdata[2*WORD_W-1:WORD_W]);
            n_fail++;
          end
        end
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        rx_wait = (rx_steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
        m_tready <= (rx_wait == 0);
      end
    end
  end

  // ------------------------------------------------------------------
  // Configuration writes. Called just after the clock rises; the caller
  // lowers cfg_valid once its run of writes is over, so valid is never
  // dropped and raised again in the same step.
  // ------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
    case (idx)
      REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: key_reg[idx[1:0]] = value;
      REG_KEY_LENGTH:  keylen_reg = value[5:0];
      REG_ROUND_COUNT: rounds_reg = value[6:0];
      default: ;
    endcase
    // Only decoded registers make the round key store stale.
    if (idx <= REG_ROUND_COUNT) sched_fresh = 1'b0;
  endtask

  task automatic queue_block(input cipher_mode_t mode, input logic [WORD_W-1:0] lo,
                             input logic [WORD_W-1:0] hi);
    block_req_t req;
    req.mode       = mode;
    req.block_low  = lo;
    req.block_high = hi;
    pending_blocks.push_back(req);
    n_queued++;
  endtask

  // Encrypts a block, then queues the decryption of the predicted ciphertext
  // so the round trip should hand back the original words.
  task automatic queue_round_trip(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    block_req_t req;
    block_res_t ct;
    req.mode       = MODE_ENCRYPT;
    req.block_low  = lo;
    req.block_high = hi;
    ct = predict_block(req);
    queue_block(MODE_ENCRYPT, lo, hi);
    queue_block(MODE_DECRYPT, ct.result_low, ct.result_high);
  endtask

  task automatic queue_random_blocks(input int n);
    for (int i = 0; i < n; i++)
      queue_block(cipher_mode_t'($urandom_range(0, 1)), rand_word(), rand_word());
  endtask

  // Waits until the block is idle: nothing queued, offered or owed. The
  // check runs at the falling edge, after the driver's updates have landed.
  task automatic settle();
    while (pending_blocks.size() != 0 || s_tvalid || owed_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    n_phases++;
  endtask

  // A random mix of register writes; lengths and round counts mostly in
  // range, sometimes below or above it, sometimes with junk high bits.
  task automatic shuffle_settings();
    logic [WORD_W-1:0] junk;
    for (int i = 0; i < KEY_WORDS; i++)
      if ($urandom_range(0, 1)) cfg_write(CFG_IDX_W'(i), rand_word());
    if ($urandom_range(0, 1)) begin
      junk = $urandom_range(0, 1) ? {$urandom, $urandom} << 6 : '0;
      case ($urandom_range(0, 9))
        0: cfg_write(REG_KEY_LENGTH, junk | $urandom_range(0, 8));
        1: cfg_write(REG_KEY_LENGTH, junk | $urandom_range(33, 63));
        default: cfg_write(REG_KEY_LENGTH, junk | $urandom_range(9, 32));
      endcase
    end
    if ($urandom_range(0, 1)) begin
      junk = $urandom_range(0, 1) ? {$urandom, $urandom} << 7 : '0;
      case ($urandom_range(0, 5))
        0: cfg_write(REG_ROUND_COUNT, junk);
        1: cfg_write(REG_ROUND_COUNT, junk | $urandom_range(65, 127));
        default: cfg_write(REG_ROUND_COUNT, junk | $urandom_range(1, 64));
      endcase
    end
    if ($urandom_range(0, 7) == 0)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand_word());
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Test sequence: a directed pass over the reset settings and the key
  // length and round count corners, then random settings with random
  // blocks, each phase drained before the registers change.
  // ------------------------------------------------------------------
  initial begin : stimulus
    for (int i = 0; i < KEY_WORDS; i++) key_reg[i] = '0;
    keylen_reg  = 6'd16;
    rounds_reg  = '0;
    sched_fresh = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: all-zero 16-byte key, default round count.
    queue_block(MODE_ENCRYPT, '0, '0);
    queue_block(MODE_DECRYPT, '0, '0);
    queue_block(MODE_ENCRYPT, ALL_ONES, ALL_ONES);
    queue_block(MODE_DECRYPT, ALL_ONES, ALL_ONES);
    queue_block(MODE_ENCRYPT, {32{2'b01}}, {32{2'b10}});
    queue_block(MODE_DECRYPT, {32{2'b10}}, {32{2'b01}});
    queue_block(MODE_ENCRYPT, ALL_ONES, '0);
    queue_block(MODE_DECRYPT, '0, ALL_ONES);
    queue_round_trip(64'h7469206564616d20, 64'h6c61766975716520);
    settle();

    // The standard 128-bit key.
    cfg_write(REG_KEY_WORD0, 64'h0706050403020100);
    cfg_write(REG_KEY_WORD1, 64'h0f0e0d0c0b0a0908);
    cfg_valid <= 1'b0;
    queue_round_trip(64'h7469206564616d20, 64'h6c61766975716520);
    settle();

    // Short key length clipped up to 9 bytes, and a single round.
    for (int i = 0; i < KEY_WORDS; i++) cfg_write(CFG_IDX_W'(i), ALL_ONES);
    cfg_write(REG_KEY_LENGTH, '0);
    cfg_write(REG_ROUND_COUNT, 64'd1);
    cfg_valid <= 1'b0;
    queue_round_trip(64'h0123456789abcdef, 64'hfedcba9876543210);
    queue_block(MODE_DECRYPT, ALL_ONES, '0);
    settle();

    // Length and round count with every bit set: 32 bytes, clipped to the
    // store size. Writes to undecoded indexes must change nothing.
    cfg_write(REG_KEY_LENGTH, ALL_ONES);
    cfg_write(REG_ROUND_COUNT, ALL_ONES);
    cfg_write(REG_SPARE_LO, '0);
    cfg_write(REG_SPARE_HI, ALL_ONES);
    cfg_valid <= 1'b0;
    queue_round_trip('0, ALL_ONES);
    queue_block(MODE_DECRYPT, 64'h8000000000000001, 64'h8000000000000001);
    settle();

    // Three key words with the default count of 33 rounds.
    cfg_write(REG_KEY_LENGTH, 64'd24);
    cfg_write(REG_ROUND_COUNT, '0);
    cfg_write(REG_KEY_WORD2, 64'h1716151413121110);
    cfg_valid <= 1'b0;
    queue_round_trip(64'h0000000000000001, 64'h8000000000000000);
    queue_block(MODE_DECRYPT, ALL_ONES, ALL_ONES);
    settle();

    // Length just past the top, two rounds.
    cfg_write(REG_KEY_LENGTH, 64'd33);
    cfg_write(REG_ROUND_COUNT, 64'd2);
    cfg_valid <= 1'b0;
    queue_round_trip(ALL_ONES, 64'h5555555555555555);
    queue_block(MODE_ENCRYPT, '0, '0);
    settle();

    while (n_queued < DIRECTED_N + RANDOM_N) begin
      shuffle_settings();
      queue_random_blocks($urandom_range(5, 40));
      settle();
    end

    // Idle tail long enough for a stray result after expansion and a full run.
    repeat (2 * (MAX_ROUNDS + 1) + 20) @(posedge clk);
    $display("Covered %0d blocks (%0d encrypt, %0d decrypt) over %0d key settings",
             n_enc + n_dec, n_enc, n_dec, n_phases);
    $display("with %0d register writes and %0d result transactions checked.",
             n_writes, n_results);
    if (n_fail == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run of about 600 blocks.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
